// ===== design/ceca_pkg.sv =====
package ceca_pkg;

  // Default number of mix steps toward black or white
  localparam int MIX_STEPS_DEF = 24;

  // Shared multiplier operand and product widths
  localparam int MUL_W  = 22;
  localparam int PROD_W = 2 * MUL_W;

  // Luminance weights, Q0.16
  localparam logic [15:0] W_RED   = 16'd13933;
  localparam logic [15:0] W_GREEN = 16'd46871;
  localparam logic [15:0] W_BLUE  = 16'd4732;

  // 0.05 and 0.179 in Q0.16
  localparam logic [16:0] LUM_OFFSET  = 17'd3277;
  localparam logic [16:0] LIGHT_LEVEL = 17'd11731;

  typedef logic [16:0] lin_rom_t [256];

  // Operations of the shared multiplier
  typedef enum logic [2:0] {
    MUL_IDLE,
    MUL_NINIT,
    MUL_RECIP,
    MUL_LUM,
    MUL_MEET,
    MUL_BEST_A,
    MUL_BEST_B
  } mul_op_t;

  // Operand sources handed to the shared multiplier
  typedef struct packed {
    mul_op_t          op;
    logic [1:0]       idx;
    logic [7:0]       fg_chan;
    logic [MUL_W-1:0] mix_num;
    logic [16:0]      lin;
    logic [12:0]      ratio;
    logic [16:0]      cur_n;
    logic [16:0]      cur_d;
    logic [16:0]      best_n;
    logic [16:0]      best_d;
  } mul_src_t;

  // Shift of the reciprocal used to divide a mix numerator by the step count
  function automatic int recip_shift(input int steps);
    return 8 + 2 * $clog2(steps);
  endfunction

  // sRGB to linear table, Q0.16, worked out at elaboration
  function automatic lin_rom_t build_lin_rom();
    lin_rom_t    rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] r;
    logic [63:0] trial;
    logic [63:0] p2;
    logic [63:0] p4;
    logic [63:0] p5;
    logic [63:0] y;
    for (int i = 0; i < 256; i++) begin
      if (i <= 10) begin
        rom[i] = 17'((64'd655360 * 64'(i) + 64'd16473) / 64'd32946);
      end else if (i == 255) begin
        rom[i] = 17'd65536;
      end else begin
        x  = (64'(1000 * i + 14025) << 32) / 64'd269025;
        x2 = (x * x) >> 32;
        r  = 64'd0;
        // Largest fifth root that does not exceed x squared, one bit a pass
        for (int b = 31; b >= 0; b--) begin
          trial = r | (64'd1 << b);
          p2    = (trial * trial) >> 32;
          p4    = (p2 * p2) >> 32;
          p5    = (p4 * trial) >> 32;
          if (p5 <= x2) begin
            r = trial;
          end
        end
        y      = (x2 * r) >> 32;
        rom[i] = 17'((y + 64'd32768) >> 16);
      end
    end
    return rom;
  endfunction

  localparam lin_rom_t LIN_ROM = build_lin_rom();

endpackage

// ===== design/ceca_mul.sv =====
module ceca_mul #(
  parameter int MIX_STEPS = ceca_pkg::MIX_STEPS_DEF
) (
  input  ceca_pkg::mul_src_t              src,
  output logic [ceca_pkg::PROD_W-1:0]     prod
);
  import ceca_pkg::*;

  localparam int RecipSh = recip_shift(MIX_STEPS);
  localparam logic [MUL_W-1:0] Recip =
    MUL_W'(((64'd1 << RecipSh) + 64'(MIX_STEPS) - 64'd1) / 64'(MIX_STEPS));
  localparam logic [MUL_W-1:0] StepsExt = MUL_W'(MIX_STEPS);

  logic [MUL_W-1:0] op_a;
  logic [MUL_W-1:0] op_b;
  logic [15:0]      weight;

  // Pick the luminance weight of the channel in flight
  always_comb begin
    case (src.idx)
      2'd0:    weight = W_RED;
      2'd1:    weight = W_GREEN;
      default: weight = W_BLUE;
    endcase
  end

  // Steer operands for the requested operation
  always_comb begin
    unique case (src.op)
      MUL_NINIT: begin
        op_a = MUL_W'(src.fg_chan);
        op_b = StepsExt;
      end
      MUL_RECIP: begin
        op_a = src.mix_num;
        op_b = Recip;
      end
      MUL_LUM: begin
        op_a = MUL_W'(src.lin);
        op_b = MUL_W'(weight);
      end
      MUL_MEET: begin
        op_a = MUL_W'(src.ratio);
        op_b = MUL_W'(src.cur_d);
      end
      MUL_BEST_A: begin
        op_a = MUL_W'(src.cur_n);
        op_b = MUL_W'(src.best_d);
      end
      MUL_BEST_B: begin
        op_a = MUL_W'(src.best_n);
        op_b = MUL_W'(src.cur_d);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod = PROD_W'(op_a) * PROD_W'(op_b);

endmodule

// ===== design/contrast_enforce_color.sv =====
// Sequence: background and foreground luminance, then the ratio test; the foreground is
// kept when it already meets the ratio, else mix steps run from 1 until one meets it or
// MIX_STEPS is reached, each round running S_MIX, S_LUM, S_LUM_END, S_MEET and the best check.
// Throughput: one color at a time; in_ready rises together with out_valid, so a new color is
// accepted only after each result is loaded, and later while a prior result waits on out_ready.
// Reset (synchronous, active low) returns the sequencer to idle and drops out_valid.
module contrast_enforce_color #(
  parameter int MIX_STEPS = ceca_pkg::MIX_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_fg_red,
  input  logic [7:0]  in_fg_green,
  input  logic [7:0]  in_fg_blue,
  input  logic [7:0]  in_fg_alpha,
  input  logic [7:0]  in_bg_red,
  input  logic [7:0]  in_bg_green,
  input  logic [7:0]  in_bg_blue,
  input  logic [12:0] in_min_ratio,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic        out_met_minimum,
  output logic [4:0]  out_steps_taken
);
  import ceca_pkg::*;

  localparam int NumW    = $clog2(256 * MIX_STEPS);
  localparam int StepW   = $clog2(MIX_STEPS + 1);
  localparam int RecipSh = recip_shift(MIX_STEPS);
  localparam logic [NumW:0]    HalfExt  = (NumW + 1)'(MIX_STEPS / 2);
  localparam logic [StepW-1:0] LastStep = StepW'(MIX_STEPS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LUM,
    S_LUM_END,
    S_MEET,
    S_NINIT,
    S_MIX,
    S_BEST_A,
    S_BEST_B,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    SRC_BG,
    SRC_FG,
    SRC_CAND
  } lum_src_t;

  state_t           state_r;
  lum_src_t         src_r;
  logic [1:0]       cnt_r;
  logic [StepW-1:0] step_r;

  logic [7:0]       fg_r [3];
  logic [7:0]       bg_r [3];
  logic [7:0]       cand_r [3];
  logic [NumW-1:0]  num_r [3];
  logic [7:0]       alpha_r;
  logic [12:0]      ratio_r;
  logic             to_black_r;

  logic [16:0]      lin_r;
  logic [32:0]      acc_r;
  logic [16:0]      lb_r;
  logic [16:0]      cur_n_r;
  logic [16:0]      cur_d_r;
  logic [16:0]      best_n_r;
  logic [16:0]      best_d_r;
  logic [33:0]      hold_r;

  logic [7:0]       res_r [3];
  logic [StepW-1:0] res_step_r;
  logic             met_r;

  logic             out_valid_r;
  logic [7:0]       out_red_r;
  logic [7:0]       out_green_r;
  logic [7:0]       out_blue_r;
  logic [7:0]       out_alpha_r;
  logic             out_met_r;
  logic [4:0]       out_steps_r;

  mul_src_t         mul_src;
  logic [PROD_W-1:0] mul_prod;

  logic [7:0]       lum_chan;
  logic [16:0]      lum_rnd;
  logic [16:0]      cont_n;
  logic [16:0]      cont_d;
  logic             meet;
  logic             better;
  logic [8:0]       delta [3];
  logic [NumW-1:0]  num_adv [3];
  logic [NumW-1:0]  num_init;
  logic [7:0]       fg_sel;
  logic [NumW-1:0]  num_sel;
  logic [8:0]       delta_sel;

  ceca_mul #(
    .MIX_STEPS (MIX_STEPS)
  ) u_mul (
    .src  (mul_src),
    .prod (mul_prod)
  );

  // Select the channel whose linear value is fetched this cycle
  always_comb begin
    lum_chan = 8'd0;
    case (cnt_r)
      2'd0: begin
        lum_chan = (src_r == SRC_BG) ? bg_r[0] : (src_r == SRC_FG) ? fg_r[0] : cand_r[0];
      end
      2'd1: begin
        lum_chan = (src_r == SRC_BG) ? bg_r[1] : (src_r == SRC_FG) ? fg_r[1] : cand_r[1];
      end
      2'd2: begin
        lum_chan = (src_r == SRC_BG) ? bg_r[2] : (src_r == SRC_FG) ? fg_r[2] : cand_r[2];
      end
      default: lum_chan = 8'd0;
    endcase
  end

  // Per-channel operands for the mix sequencer
  always_comb begin
    case (cnt_r)
      2'd0: begin
        fg_sel    = fg_r[0];
        num_sel   = num_r[0];
        delta_sel = delta[0];
      end
      2'd1: begin
        fg_sel    = fg_r[1];
        num_sel   = num_r[1];
        delta_sel = delta[1];
      end
      default: begin
        fg_sel    = fg_r[2];
        num_sel   = num_r[2];
        delta_sel = delta[2];
      end
    endcase
  end

  // Round the luminance sum and order it against the background
  assign lum_rnd = 17'((acc_r + 33'd32768) >> 16);
  assign cont_n  = ((lum_rnd >= lb_r) ? lum_rnd : lb_r) + LUM_OFFSET;
  assign cont_d  = ((lum_rnd >= lb_r) ? lb_r : lum_rnd) + LUM_OFFSET;

  // Ratio test and strict improvement test on the multiplier product
  assign meet   = PROD_W'({cur_n_r, 8'd0}) >= mul_prod;
  assign better = hold_r > mul_prod[33:0];

  // Per-step change of each mix numerator, and the advanced numerators
  for (genvar c = 0; c < 3; c++) begin : g_chan
    assign delta[c]   = to_black_r ? (9'd0 - {1'b0, fg_r[c]}) : (9'd255 - {1'b0, fg_r[c]});
    assign num_adv[c] = NumW'({1'b0, num_r[c]} + {{(NumW - 8){delta[c][8]}}, delta[c]});
  end

  // First-step numerator: a*STEPS + STEPS/2 + delta
  assign num_init = NumW'({1'b0, mul_prod[NumW-1:0]} + HalfExt
                          + {{(NumW - 8){delta_sel[8]}}, delta_sel});

  // Drive the shared multiplier from the sequencer state
  always_comb begin
    mul_src         = '0;
    mul_src.op      = MUL_IDLE;
    mul_src.idx     = cnt_r - 2'd1;
    mul_src.fg_chan = fg_sel;
    mul_src.mix_num = MUL_W'(num_sel);
    mul_src.lin     = lin_r;
    mul_src.ratio   = ratio_r;
    mul_src.cur_n   = cur_n_r;
    mul_src.cur_d   = cur_d_r;
    mul_src.best_n  = best_n_r;
    mul_src.best_d  = best_d_r;
    unique case (state_r)
      S_LUM:    mul_src.op = (cnt_r != 2'd0) ? MUL_LUM : MUL_IDLE;
      S_MEET:   mul_src.op = MUL_MEET;
      S_NINIT:  mul_src.op = MUL_NINIT;
      S_MIX:    mul_src.op = MUL_RECIP;
      S_BEST_A: mul_src.op = MUL_BEST_A;
      S_BEST_B: mul_src.op = MUL_BEST_B;
      default:  mul_src.op = MUL_IDLE;
    endcase
  end

  // Sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= 2'd0;
      src_r       <= SRC_BG;
    end else begin
      // Release the output register once its transfer completes
      if (out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            fg_r[0] <= in_fg_red;
            fg_r[1] <= in_fg_green;
            fg_r[2] <= in_fg_blue;
            bg_r[0] <= in_bg_red;
            bg_r[1] <= in_bg_green;
            bg_r[2] <= in_bg_blue;
            alpha_r <= in_fg_alpha;
            ratio_r <= in_min_ratio;
            src_r   <= SRC_BG;
            cnt_r   <= 2'd0;
            state_r <= S_LUM;
          end
        end

        S_LUM: begin
          // Fetch one linear value and accumulate the previous weighted one
          lin_r <= LIN_ROM[lum_chan];
          if (cnt_r == 2'd0) begin
            acc_r <= 33'd0;
          end else begin
            acc_r <= acc_r + 33'(mul_prod);
          end
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'd3) begin
            state_r <= S_LUM_END;
          end
        end

        S_LUM_END: begin
          cnt_r <= 2'd0;
          if (src_r == SRC_BG) begin
            lb_r    <= lum_rnd;
            src_r   <= SRC_FG;
            state_r <= S_LUM;
          end else begin
            cur_n_r <= cont_n;
            cur_d_r <= cont_d;
            if (src_r == SRC_FG) begin
              best_n_r <= cont_n;
              best_d_r <= cont_d;
            end
            state_r <= S_MEET;
          end
        end

        S_MEET: begin
          if (src_r == SRC_FG) begin
            res_r[0]   <= fg_r[0];
            res_r[1]   <= fg_r[1];
            res_r[2]   <= fg_r[2];
            res_step_r <= '0;
            met_r      <= meet;
            to_black_r <= lb_r >= LIGHT_LEVEL;
            cnt_r      <= 2'd0;
            state_r    <= meet ? S_DONE : S_NINIT;
          end else if (meet) begin
            res_r[0]   <= cand_r[0];
            res_r[1]   <= cand_r[1];
            res_r[2]   <= cand_r[2];
            res_step_r <= step_r;
            met_r      <= 1'b1;
            state_r    <= S_DONE;
          end else begin
            state_r <= S_BEST_A;
          end
        end

        S_NINIT: begin
          // Build the first-step numerator of each channel
          case (cnt_r)
            2'd0:    num_r[0] <= num_init;
            2'd1:    num_r[1] <= num_init;
            default: num_r[2] <= num_init;
          endcase
          if (cnt_r == 2'd2) begin
            cnt_r   <= 2'd0;
            step_r  <= StepW'(1);
            state_r <= S_MIX;
          end else begin
            cnt_r <= cnt_r + 2'd1;
          end
        end

        S_MIX: begin
          // Divide by the step count through the reciprocal
          case (cnt_r)
            2'd0:    cand_r[0] <= mul_prod[RecipSh +: 8];
            2'd1:    cand_r[1] <= mul_prod[RecipSh +: 8];
            default: cand_r[2] <= mul_prod[RecipSh +: 8];
          endcase
          if (cnt_r == 2'd2) begin
            cnt_r   <= 2'd0;
            src_r   <= SRC_CAND;
            state_r <= S_LUM;
          end else begin
            cnt_r <= cnt_r + 2'd1;
          end
        end

        S_BEST_A: begin
          hold_r  <= mul_prod[33:0];
          state_r <= S_BEST_B;
        end

        S_BEST_B: begin
          if (better) begin
            res_r[0]   <= cand_r[0];
            res_r[1]   <= cand_r[1];
            res_r[2]   <= cand_r[2];
            res_step_r <= step_r;
            best_n_r   <= cur_n_r;
            best_d_r   <= cur_d_r;
          end
          if (step_r == LastStep) begin
            state_r <= S_DONE;
          end else begin
            // Advance to the next mix step
            step_r   <= step_r + StepW'(1);
            num_r[0] <= num_adv[0];
            num_r[1] <= num_adv[1];
            num_r[2] <= num_adv[2];
            cnt_r    <= 2'd0;
            state_r  <= S_MIX;
          end
        end

        S_DONE: begin
          // Hold the result until the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_red_r   <= res_r[0];
            out_green_r <= res_r[1];
            out_blue_r  <= res_r[2];
            out_alpha_r <= alpha_r;
            out_met_r   <= met_r;
            out_steps_r <= 5'(res_step_r);
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_red         = out_red_r;
  assign out_green       = out_green_r;
  assign out_blue        = out_blue_r;
  assign out_alpha       = out_alpha_r;
  assign out_met_minimum = out_met_r;
  assign out_steps_taken = out_steps_r;

`ifndef NO_ASSERTIONS
  // A transfer in starts the sequencer, so ready must drop
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready held after input transfer");

  // Mix rounds only run on steps 1 through MIX_STEPS
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MIX || state_r == S_BEST_B) |-> (step_r >= StepW'(1) && step_r <= LastStep))
    else $error("mix step out of range");

  // Channel counter never passes the last channel in mix phases
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MIX || state_r == S_NINIT) |-> cnt_r != 2'd3)
    else $error("channel counter out of range in mix phase");

  // A new result is only loaded from the done state
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_DONE))
    else $error("out_valid rose outside done state");

  // The background luminance pass always precedes the foreground pass
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MEET && src_r == SRC_BG) |-> 1'b0)
    else $error("ratio test reached with background source");
`endif

endmodule

// ===== tb/sv/contrast_checker.sv =====
module contrast_checker #(
  parameter int MIX_STEPS = ceca_pkg::MIX_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_fg_red,
  input  logic [7:0]  in_fg_green,
  input  logic [7:0]  in_fg_blue,
  input  logic [7:0]  in_fg_alpha,
  input  logic [7:0]  in_bg_red,
  input  logic [7:0]  in_bg_green,
  input  logic [7:0]  in_bg_blue,
  input  logic [12:0] in_min_ratio,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  input  logic [7:0]  out_alpha,
  input  logic        out_met_minimum,
  input  logic [4:0]  out_steps_taken,
  output int          mismatch_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Luminance weights and thresholds, Q0.16
  localparam logic [63:0] WEIGHT_R  = 64'd13933;
  localparam logic [63:0] WEIGHT_G  = 64'd46871;
  localparam logic [63:0] WEIGHT_B  = 64'd4732;
  localparam logic [63:0] FLARE     = 64'd3277;
  localparam logic [16:0] LIGHT_BG  = 17'd11731;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       met;
    logic [4:0] steps;
  } adjusted_color_t;

  adjusted_color_t expected_colors[$];
  logic [16:0]     lin_lut[256];

  function automatic logic [63:0] q32_mul(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> 32;
  endfunction

  // sRGB code to linear light, Q0.16
  function automatic logic [16:0] srgb_linear(input int code);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] root;
    logic [63:0] trial;
    logic [63:0] p2;
    logic [63:0] p4;
    if (code <= 10) begin
      return 17'((64'd655360 * 64'(code) + 64'd16473) / 64'd32946);
    end
    if (code == 255) begin
      return 17'd65536;
    end
    x    = (64'(1000 * code + 14025) << 32) / 64'd269025;
    x2   = q32_mul(x, x);
    root = 64'd0;
    // Bitwise search for the largest fifth root not above x squared
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      p2    = q32_mul(trial, trial);
      p4    = q32_mul(p2, p2);
      if (q32_mul(p4, trial) <= x2) begin
        root = trial;
      end
    end
    return 17'((q32_mul(x2, root) + 64'd32768) >> 16);
  endfunction

  initial begin
    for (int i = 0; i < 256; i++) begin
      lin_lut[i] = srgb_linear(i);
    end
  end

  function automatic logic [16:0] rel_luminance(input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b);
    logic [63:0] acc;
    acc = WEIGHT_R * 64'(lin_lut[r]) + WEIGHT_G * 64'(lin_lut[g]) + WEIGHT_B * 64'(lin_lut[b]);
    return 17'((acc + 64'd32768) >> 16);
  endfunction

  // Contrast as num/den, brighter over darker, both offset by the flare term
  function automatic void contrast_pair(input logic [16:0] la, input logic [16:0] lb,
                                        output logic [63:0] num, output logic [63:0] den);
    num = (la >= lb ? 64'(la) : 64'(lb)) + FLARE;
    den = (la >= lb ? 64'(lb) : 64'(la)) + FLARE;
  endfunction

  function automatic bit meets_ratio(input logic [63:0] num, input logic [63:0] den,
                                     input logic [12:0] ratio);
    return (num * 64'd256) >= (64'(ratio) * den);
  endfunction

  function automatic logic [7:0] mix_toward(input int unsigned a, input int unsigned t,
                                            input int unsigned s);
    return 8'((a * (MIX_STEPS - s) + t * s + MIX_STEPS / 2) / MIX_STEPS);
  endfunction

  function automatic adjusted_color_t predict_adjusted_color(
    input logic [7:0] fr, input logic [7:0] fgn, input logic [7:0] fb, input logic [7:0] fa,
    input logic [7:0] br, input logic [7:0] bgn, input logic [7:0] bb,
    input logic [12:0] ratio);
    adjusted_color_t res;
    logic [16:0]     lum_bg;
    logic [63:0]     best_num;
    logic [63:0]     best_den;
    logic [63:0]     num;
    logic [63:0]     den;
    logic [7:0]      target;
    logic [7:0]      cr;
    logic [7:0]      cg;
    logic [7:0]      cb;
    res.red   = fr;
    res.green = fgn;
    res.blue  = fb;
    res.alpha = fa;
    res.met   = 1'b0;
    res.steps = 5'd0;
    lum_bg = rel_luminance(br, bgn, bb);
    contrast_pair(rel_luminance(fr, fgn, fb), lum_bg, best_num, best_den);
    if (meets_ratio(best_num, best_den, ratio)) begin
      res.met = 1'b1;
      return res;
    end
    target = (lum_bg >= LIGHT_BG) ? 8'd0 : 8'd255;
    // Walk the mix steps; keep the first that meets, else the strictly best
    for (int s = 1; s <= MIX_STEPS; s++) begin
      cr = mix_toward(fr, target, s);
      cg = mix_toward(fgn, target, s);
      cb = mix_toward(fb, target, s);
      contrast_pair(rel_luminance(cr, cg, cb), lum_bg, num, den);
      if (meets_ratio(num, den, ratio) || (num * best_den > best_num * den)) begin
        res.red   = cr;
        res.green = cg;
        res.blue  = cb;
        res.steps = 5'(s);
        best_num  = num;
        best_den  = den;
        if (meets_ratio(num, den, ratio)) begin
          res.met = 1'b1;
          return res;
        end
      end
    end
    return res;
  endfunction

  task automatic check_field(input string field, input logic [7:0] expected,
                             input logic [7:0] actual);
    if (actual !== expected) begin
      $error("%s: expected %0d, got %0d", field, expected, actual);
      mismatch_count++;
    end
  endtask

  // Retire result transfers first, then queue the prediction for a new input
  always @(posedge clk) begin : track
    adjusted_color_t exp_color;
    if (!rst_n) begin
      expected_colors.delete();
      mismatch_count = 0;
      pending_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_colors.size() == 0) begin
          $error("result transfer with nothing expected: rgba %0d %0d %0d %0d",
                 out_red, out_green, out_blue, out_alpha);
          mismatch_count++;
        end else begin
          exp_color = expected_colors.pop_front();
          check_field("out_red", exp_color.red, out_red);
          check_field("out_green", exp_color.green, out_green);
          check_field("out_blue", exp_color.blue, out_blue);
          check_field("out_alpha", exp_color.alpha, out_alpha);
          check_field("out_met_minimum", 8'(exp_color.met), 8'(out_met_minimum));
          check_field("out_steps_taken", 8'(exp_color.steps), 8'(out_steps_taken));
        end
      end
      if (in_valid && in_ready) begin
        expected_colors.insert(expected_colors.size(), predict_adjusted_color(
          in_fg_red, in_fg_green, in_fg_blue, in_fg_alpha,
          in_bg_red, in_bg_green, in_bg_blue, in_min_ratio));
      end
      pending_count <= expected_colors.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS        = ceca_pkg::MIX_STEPS_DEF;
  localparam int MAX_IDLE     = 18;
  localparam int RANDOM_ITEMS = 1900;
  localparam int DRAIN_CYCLES = 15 + 11 * STEPS + 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_fg_red = 8'd0;
  logic [7:0]  in_fg_green = 8'd0;
  logic [7:0]  in_fg_blue = 8'd0;
  logic [7:0]  in_fg_alpha = 8'd0;
  logic [7:0]  in_bg_red = 8'd0;
  logic [7:0]  in_bg_green = 8'd0;
  logic [7:0]  in_bg_blue = 8'd0;
  logic [12:0] in_min_ratio = 13'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic        out_met_minimum;
  logic [4:0]  out_steps_taken;
  int          mismatch_count;
  int          pending_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  contrast_enforce_color #(.MIX_STEPS(STEPS)) dut (.*);

  contrast_checker #(.MIX_STEPS(STEPS)) u_color_check (.*);

  // Result side: stall a random number of cycles before each transfer
  int unsigned rx_hold = 0;
  int unsigned rx_count = 0;
  bit          rx_steady = 1'b0;

  always @(posedge clk) begin : rx_side
    int unsigned stall;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      rx_count <= rx_count + 1;
      if (rx_count % 40 == 0) begin
        rx_steady <= ($urandom_range(0, 3) == 0);
      end
      stall = rx_steady ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall != 0) begin
        out_ready <= 1'b0;
        rx_hold   <= stall;
      end
    end else if (!out_ready) begin
      if (rx_hold <= 1) begin
        out_ready <= 1'b1;
      end else begin
        rx_hold <= rx_hold - 1;
      end
    end
  end

  // Input side: idle a random gap, then hold the item until its transfer
  int unsigned items_sent = 0;
  bit          tx_steady = 1'b0;

  task automatic send_color(input logic [7:0] fr, input logic [7:0] fgn,
                            input logic [7:0] fb, input logic [7:0] fa,
                            input logic [7:0] br, input logic [7:0] bgn,
                            input logic [7:0] bb, input logic [12:0] ratio);
    int unsigned gap;
    if (items_sent % 50 == 0) begin
      tx_steady = ($urandom_range(0, 3) == 0);
    end
    gap = tx_steady ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_fg_red    <= fr;
    in_fg_green  <= fgn;
    in_fg_blue   <= fb;
    in_fg_alpha  <= fa;
    in_bg_red    <= br;
    in_bg_green  <= bgn;
    in_bg_blue   <= bb;
    in_min_ratio <= ratio;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_random_color();
    logic [7:0]  fr;
    logic [7:0]  fgn;
    logic [7:0]  fb;
    logic [7:0]  br;
    logic [7:0]  bgn;
    logic [7:0]  bb;
    logic [12:0] ratio;
    br  = 8'($urandom_range(0, 255));
    bgn = 8'($urandom_range(0, 255));
    bb  = 8'($urandom_range(0, 255));
    // Low-contrast pairs force long mix walks
    if ($urandom_range(0, 2) == 0) begin
      fr  = br + 8'($urandom_range(0, 24)) - 8'd12;
      fgn = bgn + 8'($urandom_range(0, 24)) - 8'd12;
      fb  = bb + 8'($urandom_range(0, 24)) - 8'd12;
    end else begin
      fr  = 8'($urandom_range(0, 255));
      fgn = 8'($urandom_range(0, 255));
      fb  = 8'($urandom_range(0, 255));
    end
    case ($urandom_range(0, 9))
      0:       ratio = 13'($urandom_range(0, 255));
      1, 2, 3: ratio = 13'($urandom_range(256, 1792));
      4:       ratio = $urandom_range(0, 1) ? 13'd1152 : 13'd1792;
      5, 6:    ratio = 13'($urandom_range(1792, 5376));
      7:       ratio = 13'($urandom_range(5377, 8191));
      default: ratio = 13'($urandom_range(0, 8191));
    endcase
    send_color(fr, fgn, fb, 8'($urandom_range(0, 255)), br, bgn, bb, ratio);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Ratio zero, and full-scale extremes at exactly 21.0
    send_color(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 13'd0);
    send_color(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 13'd5376);
    send_color(8'd0, 8'd0, 8'd0, 8'd128, 8'd255, 8'd255, 8'd255, 13'd5376);
    send_color(8'd128, 8'd128, 8'd128, 8'd1, 8'd255, 8'd255, 8'd255, 13'd5376);
    send_color(8'd128, 8'd128, 8'd128, 8'd254, 8'd0, 8'd0, 8'd0, 13'd5376);
    // Ratios above 21.0 are never met
    send_color(8'd128, 8'd128, 8'd128, 8'd254, 8'd0, 8'd0, 8'd0, 13'd8191);
    send_color(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 13'd8191);
    send_color(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 13'd8191);
    // Identical colors: ratio 1.0 passes, just above it must mix
    send_color(8'd200, 8'd30, 8'd90, 8'd17, 8'd200, 8'd30, 8'd90, 13'd256);
    send_color(8'd200, 8'd30, 8'd90, 8'd17, 8'd200, 8'd30, 8'd90, 13'd257);
    // Backgrounds straddling the light threshold pick opposite mix targets
    send_color(8'd117, 8'd117, 8'd117, 8'd60, 8'd117, 8'd117, 8'd117, 13'd1152);
    send_color(8'd118, 8'd118, 8'd118, 8'd61, 8'd118, 8'd118, 8'd118, 13'd1152);
    send_color(8'd119, 8'd119, 8'd119, 8'd62, 8'd119, 8'd119, 8'd119, 13'd1152);
    send_color(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 13'd1152);
    send_color(8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 13'd1792);
    // Single-bit and alternating patterns, linear-segment table entries
    send_color(8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd32, 8'd64, 13'd64);
    send_color(8'd10, 8'd11, 8'd9, 8'd128, 8'd12, 8'd10, 8'd11, 13'd768);
    send_color(8'd127, 8'd191, 8'd223, 8'd239, 8'd247, 8'd251, 8'd253, 13'd4096);
    send_color(8'd85, 8'd170, 8'd85, 8'd170, 8'd170, 8'd85, 8'd170, 13'd5461);
    send_color(8'd170, 8'd85, 8'd170, 8'd85, 8'd85, 8'd170, 8'd85, 13'd2730);

    repeat (RANDOM_ITEMS) send_random_color();
    in_valid <= 1'b0;

    // Drain outstanding results, then watch for stray transfers
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
